FILE: rtl/grid_dda_ray_column_caster_assert.svh
// Assertion macros used by the caster's checker file.
`ifndef GRID_DDA_RAY_COLUMN_CASTER_ASSERT_SVH
`define GRID_DDA_RAY_COLUMN_CASTER_ASSERT_SVH

// Clocked assertion, quiet while reset is high.
`define DDARC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DDARC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ddarc_pkg.sv
// Shared types, constants and the colour table of the column caster.
`default_nettype none
package ddarc_pkg;

  localparam int GRID_COLS_DEF   = 32;
  localparam int GRID_ROWS_DEF   = 32;
  localparam int VIEW_WIDTH_DEF  = 800;
  localparam int VIEW_HEIGHT_DEF = 600;

  typedef enum logic [2:0] {
    CFG_POS_X   = 3'd0,
    CFG_POS_Y   = 3'd1,
    CFG_DIR_X   = 3'd2,
    CFG_DIR_Y   = 3'd3,
    CFG_PLANE_X = 3'd4,
    CFG_PLANE_Y = 3'd5
  } cfg_reg_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  typedef enum logic [2:0] {
    WALL_OPEN  = 3'd0,
    WALL_RED   = 3'd1,
    WALL_GREEN = 3'd2,
    WALL_BLUE  = 3'd3,
    WALL_WHITE = 3'd4
  } wall_t;

  // one queued item as the front end classified it
  typedef struct packed {
    logic       cast;
    logic       wr_ok;
    logic [9:0] column;
    logic [4:0] cell_x;
    logic [4:0] cell_y;
    logic [2:0] code;
  } item_t;

  typedef struct packed {
    logic [20:0] pos_x;
    logic [20:0] pos_y;
    logic [17:0] dir_x;
    logic [17:0] dir_y;
    logic [17:0] plane_x;
    logic [17:0] plane_y;
  } cam_cfg_t;

  function automatic logic [23:0] colour(input logic [2:0] code, input logic yside);
    logic [7:0] r, g, b;
    begin
      case (code)
        WALL_RED: begin
          r = 8'd255; g = 8'd0; b = 8'd0;
        end
        WALL_GREEN: begin
          r = 8'd0; g = 8'd255; b = 8'd0;
        end
        WALL_BLUE: begin
          r = 8'd0; g = 8'd0; b = 8'd255;
        end
        WALL_WHITE: begin
          r = 8'd255; g = 8'd255; b = 8'd255;
        end
        default: begin
          r = 8'd255; g = 8'd255; b = 8'd0;
        end
      endcase
      if (yside) begin
        r = r >> 1; g = g >> 1; b = b >> 1;
      end
      colour = {r, g, b};
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/grid_dda_ray_column_caster.sv
// Top level of the grid DDA column caster: config registers, front end and engine.
// After reset the map is cleared one cell a cycle, with the input stalled. A write beat is
// written to the map from the idle state. A cast takes its camera offset by a constant
// reciprocal multiply, then runs through a shared one-bit-per-cycle divider up to three times
// (one per nonzero ray axis, one for the line height), then walks the map through the single
// map port, each grid step passing through the step, address and read states, at most
// GRID_COLS+GRID_ROWS steps. A two-beat input queue and the output register let either
// side stall on its own.
`default_nettype none
module grid_dda_ray_column_caster #(
  parameter int GRID_COLS   = ddarc_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS   = ddarc_pkg::GRID_ROWS_DEF,
  parameter int VIEW_WIDTH  = ddarc_pkg::VIEW_WIDTH_DEF,
  parameter int VIEW_HEIGHT = ddarc_pkg::VIEW_HEIGHT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [20:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [9:0]  column,
  input  wire logic [4:0]  cell_x,
  input  wire logic [4:0]  cell_y,
  input  wire logic [2:0]  cell_code,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_column,
  output logic [9:0]       draw_start,
  output logic [9:0]       draw_end,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic             hit_side,
  output logic [2:0]       wall_code
);
  import ddarc_pkg::*;

  cam_cfg_t cfg;
  logic     clearing, q_valid, q_pop;
  item_t    q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pos_x   <= 21'd131072;
      cfg.pos_y   <= 21'd131072;
      cfg.dir_x   <= 18'h30000;
      cfg.dir_y   <= 18'd0;
      cfg.plane_x <= 18'd0;
      cfg.plane_y <= 18'd43254;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_POS_X:   cfg.pos_x   <= cfg_data;
        CFG_POS_Y:   cfg.pos_y   <= cfg_data;
        CFG_DIR_X:   cfg.dir_x   <= cfg_data[17:0];
        CFG_DIR_Y:   cfg.dir_y   <= cfg_data[17:0];
        CFG_PLANE_X: cfg.plane_x <= cfg_data[17:0];
        CFG_PLANE_Y: cfg.plane_y <= cfg_data[17:0];
        default:     cfg <= cfg;
      endcase
    end
  end

  ddarc_front #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .column    (column),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .cell_code (cell_code),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  ddarc_back #(
    .GRID_COLS   (GRID_COLS),
    .GRID_ROWS   (GRID_ROWS),
    .VIEW_WIDTH  (VIEW_WIDTH),
    .VIEW_HEIGHT (VIEW_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .clearing   (clearing),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_column (out_column),
    .draw_start (draw_start),
    .draw_end   (draw_end),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .hit_side   (hit_side),
    .wall_code  (wall_code)
  );
endmodule
`default_nettype wire

FILE: rtl/ddarc_front.sv
// Input side: takes beats, classifies them and queues them for the engine.
`default_nettype none
module ddarc_front #(
  parameter int GRID_COLS = ddarc_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = ddarc_pkg::GRID_ROWS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              operation,
  input  wire logic [9:0]        column,
  input  wire logic [4:0]        cell_x,
  input  wire logic [4:0]        cell_y,
  input  wire logic [2:0]        cell_code,
  input  wire logic              clearing,
  output logic                   q_valid,
  output ddarc_pkg::item_t       q_item,
  input  wire logic              q_pop
);
  import ddarc_pkg::*;

  item_t      slots [2];
  logic       rd_ptr, wr_ptr;
  logic [1:0] count;
  logic       push;
  item_t      item_in;

  assign in_stall = (count == 2'd2) || clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_comb begin
    item_in.cast   = (operation == OP_CAST);
    item_in.wr_ok  = (32'(cell_x) < GRID_COLS) && (32'(cell_y) < GRID_ROWS);
    item_in.column = column;
    item_in.cell_x = cell_x;
    item_in.cell_y = cell_y;
    item_in.code   = cell_code;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop && q_valid) rd_ptr <= !rd_ptr;
      case ({push, q_pop && q_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ddarc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the engine.
`default_nettype none
module ddarc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] num,
  input  wire logic [33:0] den,
  output logic             done,
  output logic [32:0]      quo
);
  logic [32:0] num_sh;
  logic [33:0] rem;
  logic [33:0] den_r;
  logic [5:0]  cnt;
  logic        busy;
  logic [34:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem, num_sh[32]};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= !start && busy && (cnt == 6'd1);
      if (start) begin
        busy   <= 1'b1;
        cnt    <= 6'd33;
        num_sh <= num;
        den_r  <= den;
        rem    <= 34'd0;
        quo    <= 33'd0;
      end else if (busy) begin
        num_sh <= {num_sh[31:0], 1'b0};
        rem    <= fits ? 34'(rem_sh - {1'b0, den_r}) : rem_sh[33:0];
        quo    <= {quo[31:0], fits};
        cnt    <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ddarc_back.sv
// Engine: map memory, ray setup, grid walk and stripe computation.
`default_nettype none
module ddarc_back #(
  parameter int GRID_COLS   = ddarc_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS   = ddarc_pkg::GRID_ROWS_DEF,
  parameter int VIEW_WIDTH  = ddarc_pkg::VIEW_WIDTH_DEF,
  parameter int VIEW_HEIGHT = ddarc_pkg::VIEW_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  ddarc_pkg::cam_cfg_t    cfg,
  output logic                   clearing,
  input  wire logic              q_valid,
  input  ddarc_pkg::item_t       q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [9:0]             out_column,
  output logic [9:0]             draw_start,
  output logic [9:0]             draw_end,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  output logic                   hit_side,
  output logic [2:0]             wall_code
);
  import ddarc_pkg::*;

  localparam int CELLS    = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int STEP_CAP = GRID_COLS + GRID_ROWS;
  localparam int LINE_CAP = 2 * VIEW_HEIGHT;
  localparam int HALF_H   = VIEW_HEIGHT / 2;
  localparam logic [55:0] SAT_DIST = 56'd1 << 48;
  // column * 2^17 / VIEW_WIDTH = column * CAM_A + (column * CAM_B) / VIEW_WIDTH,
  // the last term by an exact reciprocal multiply for operands below 2^20
  localparam logic [27:0] CAM_A = 28'((1 << 17) / VIEW_WIDTH);
  localparam logic [19:0] CAM_B = 20'((1 << 17) % VIEW_WIDTH);
  localparam int          CAM_K = 20 + $clog2(VIEW_WIDTH);
  localparam logic [41:0] CAM_M =
    42'(((64'd1 << CAM_K) + 64'(VIEW_WIDTH) - 64'd1) / 64'(VIEW_WIDTH));

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CAM, ST_RAY_MUL, ST_RAY_ADD, ST_DX_START, ST_DX_WAIT,
    ST_DY_START, ST_DY_WAIT, ST_SIDE, ST_STEP, ST_ADDR, ST_READ, ST_PERP,
    ST_LINE_WAIT, ST_FINISH
  } state_t;

  state_t state;

  logic [2:0]        mem [CELLS];
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;
  logic [2:0]        mem_wd, mem_rd;
  logic [ADDR_W:0]   clr_cnt;

  logic        div_start, div_done;
  logic [32:0] div_num, div_q;
  logic [33:0] div_den;

  logic [9:0]         column_r;
  logic [19:0]        cam_t;
  logic [41:0]        cam_prod;
  logic signed [27:0] cam;
  logic signed [45:0] prod_x, prod_y;
  logic [31:0]        ray_x, ray_y;
  logic [55:0]        dlx, dly, sdx, sdy;
  logic [7:0]         mx, my, n;
  logic               side;
  logic [2:0]         code;
  logic [11:0]        line;

  logic [30:0] mag_x, mag_y;
  logic [16:0] fx, fy;
  logic [49:0] side_px, side_py;
  logic        zx, zy, out_grid;
  logic [55:0] perp;
  logic [10:0] half;
  logic [11:0] lo_sum;
  logic [9:0]  start_row, end_row;
  logic [23:0] rgb;

  ddarc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    cam_prod = 42'(cam_t) * CAM_M;
    zx      = (ray_x == 32'd0);
    zy      = (ray_y == 32'd0);
    mag_x   = ray_x[31] ? 31'(-ray_x) : ray_x[30:0];
    mag_y   = ray_y[31] ? 31'(-ray_y) : ray_y[30:0];
    fx      = ray_x[31] ? {1'b0, cfg.pos_x[15:0]} : 17'h10000 - {1'b0, cfg.pos_x[15:0]};
    fy      = ray_y[31] ? {1'b0, cfg.pos_y[15:0]} : 17'h10000 - {1'b0, cfg.pos_y[15:0]};
    side_px = fx * dlx[32:0];
    side_py = fy * dly[32:0];
    out_grid = mx[7] || my[7] || (32'(mx) >= GRID_COLS) || (32'(my) >= GRID_ROWS);
    perp    = side ? sdy - dly : sdx - dlx;
    half    = line[11:1];
    lo_sum  = {1'b0, half} + 12'(HALF_H);
    start_row = (32'(half) >= HALF_H) ? 10'd0 : 10'(HALF_H - 32'(half));
    end_row   = (32'(lo_sum) >= VIEW_HEIGHT) ? 10'(VIEW_HEIGHT - 1) : lo_sum[9:0];
    rgb     = colour(code, side);
  end

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ADDR_W'(32'(q_item.cell_x) * GRID_ROWS + 32'(q_item.cell_y));
    mem_wd = q_item.code;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt[ADDR_W-1:0];
      mem_wd = WALL_OPEN;
    end else if (state == ST_IDLE && q_valid && !q_item.cast && q_item.wr_ok) begin
      mem_we = 1'b1;
    end
    mem_re = (state == ST_ADDR) && !out_grid;
    mem_ra = ADDR_W'(32'(mx[5:0]) * GRID_ROWS + 32'(my[5:0]));
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_rd <= mem[mem_ra];
  end

  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_FINISH) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == CELLS - 1) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (q_valid && q_item.cast) begin
            column_r <= q_item.column;
            cam_t    <= 20'(q_item.column) * CAM_B;
            state    <= ST_CAM;
          end
        end
        ST_CAM: begin
          cam   <= $signed(28'(column_r) * CAM_A + 28'(cam_prod >> CAM_K)) - 28'sd65536;
          state <= ST_RAY_MUL;
        end
        ST_RAY_MUL: begin
          prod_x <= $signed(cfg.plane_x) * cam;
          prod_y <= $signed(cfg.plane_y) * cam;
          state  <= ST_RAY_ADD;
        end
        ST_RAY_ADD: begin
          ray_x <= {{14{cfg.dir_x[17]}}, cfg.dir_x} + {{2{prod_x[45]}}, prod_x[45:16]};
          ray_y <= {{14{cfg.dir_y[17]}}, cfg.dir_y} + {{2{prod_y[45]}}, prod_y[45:16]};
          state <= ST_DX_START;
        end
        ST_DX_START: begin
          if (zx) begin
            dlx   <= SAT_DIST;
            state <= ST_DY_START;
          end else begin
            div_num   <= 33'h1_0000_0000;
            div_den   <= {3'd0, mag_x};
            div_start <= 1'b1;
            state     <= ST_DX_WAIT;
          end
        end
        ST_DX_WAIT: begin
          div_start <= 1'b0;
          if (div_done) begin
            dlx   <= 56'(div_q);
            state <= ST_DY_START;
          end
        end
        ST_DY_START: begin
          if (zy) begin
            dly   <= SAT_DIST;
            state <= ST_SIDE;
          end else begin
            div_num   <= 33'h1_0000_0000;
            div_den   <= {3'd0, mag_y};
            div_start <= 1'b1;
            state     <= ST_DY_WAIT;
          end
        end
        ST_DY_WAIT: begin
          div_start <= 1'b0;
          if (div_done) begin
            dly   <= 56'(div_q);
            state <= ST_SIDE;
          end
        end
        ST_SIDE: begin
          sdx   <= zx ? SAT_DIST : 56'(side_px[49:16]);
          sdy   <= zy ? SAT_DIST : 56'(side_py[49:16]);
          mx    <= {3'd0, cfg.pos_x[20:16]};
          my    <= {3'd0, cfg.pos_y[20:16]};
          n     <= 8'd0;
          side  <= 1'b1;
          state <= ST_STEP;
        end
        ST_STEP: begin
          if (32'(n) == STEP_CAP) begin
            code  <= WALL_OPEN;
            state <= ST_PERP;
          end else begin
            n <= n + 8'd1;
            if (sdx < sdy) begin
              sdx  <= sdx + dlx;
              mx   <= zx ? mx : (ray_x[31] ? mx - 8'd1 : mx + 8'd1);
              side <= 1'b0;
            end else begin
              sdy  <= sdy + dly;
              my   <= zy ? my : (ray_y[31] ? my - 8'd1 : my + 8'd1);
              side <= 1'b1;
            end
            state <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          if (out_grid) begin
            code  <= WALL_OPEN;
            state <= ST_PERP;
          end else begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          code  <= mem_rd;
          state <= (mem_rd != WALL_OPEN) ? ST_PERP : ST_STEP;
        end
        ST_PERP: begin
          if (perp == 56'd0) begin
            line  <= 12'(LINE_CAP);
            state <= ST_FINISH;
          end else begin
            div_num   <= 33'(VIEW_HEIGHT) << 16;
            div_den   <= (perp[55:34] != '0) ? '1 : perp[33:0];
            div_start <= 1'b1;
            state     <= ST_LINE_WAIT;
          end
        end
        ST_LINE_WAIT: begin
          div_start <= 1'b0;
          if (div_done) begin
            line  <= (div_q > 33'(LINE_CAP)) ? 12'(LINE_CAP) : div_q[11:0];
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            out_column <= column_r;
            draw_start <= start_row;
            draw_end   <= end_row;
            red        <= rgb[23:16];
            green      <= rgb[15:8];
            blue       <= rgb[7:0];
            hit_side   <= side;
            wall_code  <= code;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ddarc_checker.sv
// Port-level checks of the column caster, bound to its top level.
`default_nettype none
`include "grid_dda_ray_column_caster_assert.svh"
module ddarc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [9:0] out_column,
  input wire logic [9:0] draw_start,
  input wire logic [9:0] draw_end,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue,
  input wire logic       hit_side,
  input wire logic [2:0] wall_code
);
  `DDARC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_column) && $stable(draw_start) && $stable(draw_end) && $stable(wall_code), "stalled result changed")
  `DDARC_ASSERT(a_rows_order, out_valid |-> draw_start <= draw_end, "stripe start below end")
  `DDARC_ASSERT(a_open_yellow, out_valid && wall_code == 3'd0 |-> blue == 8'd0 && red == green && (hit_side ? red == 8'd127 : red == 8'd255), "escaped ray not yellow")
  `DDARC_ASSERT(a_red_shade, out_valid && wall_code == 3'd1 |-> green == 8'd0 && blue == 8'd0 && (hit_side ? red == 8'd127 : red == 8'd255), "red wall shading wrong")
  `DDARC_ASSERT_RST(a_reset_quiet, rst |=> !out_valid, "result after reset")
endmodule

bind grid_dda_ray_column_caster ddarc_checker u_ddarc_checker (.*);
`default_nettype wire
